### rtl/mcls_pkg.sv
// shared constants and types for the motor current limit scaler
`default_nettype none
package mcls_pkg;

	localparam int SCALE_FRAC_BITS_DEF = 16;
	localparam int CAND_N = 5;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BACK_EMF_GAIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_DROP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_POWER = 2'd2;

	localparam logic [15:0] GAIN_RST = 16'd256;
	localparam logic [14:0] DROP_RST = 15'd1000;
	localparam logic [15:0] MAXP_RST = 16'd255;

	localparam int PWR_NW = 31;
	localparam logic [16:0] PWR_SAT = 17'd65535;

	typedef enum logic [1:0] {
		KIND_UNSCALED = 2'd0,
		KIND_SCALED = 2'd1,
		KIND_CLAMPED = 2'd2
	} kind_t;

endpackage
`default_nettype wire

### rtl/mcls_if.sv
// request, result and configuration channel interfaces
`default_nettype none
interface mcls_sample_if;
	logic valid;
	logic ready;
	logic signed [15:0] speed_left;
	logic signed [15:0] speed_right;
	logic signed [15:0] target_left;
	logic signed [15:0] target_right;
	logic [15:0] battery_mv;
	modport source(output valid, speed_left, speed_right, target_left, target_right,
		battery_mv, input ready);
	modport sink(input valid, speed_left, speed_right, target_left, target_right,
		battery_mv, output ready);
endinterface

interface mcls_result_if;
	logic valid;
	logic ready;
	logic signed [16:0] power_left;
	logic signed [16:0] power_right;
	logic [1:0] limit_kind;
	logic battery_fault;
	modport source(output valid, power_left, power_right, limit_kind, battery_fault,
		input ready);
	modport sink(input valid, power_left, power_right, limit_kind, battery_fault,
		output ready);
endinterface

interface mcls_cfg_if import mcls_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/mcls_div.sv
// pipelined restoring divider, one quotient bit per stage, with a tag carried alongside
`default_nettype none
module mcls_div #(
	parameter int NW = 32,
	parameter int DW = 16,
	parameter int SW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] tag_i,
	output logic      [NW-1:0] quo,
	output logic      [SW-1:0] tag_o
);

	logic [DW-1:0] rem_s [1:NW];
	logic [NW-1:0] nq_s  [1:NW];
	logic [DW-1:0] den_s [1:NW];
	logic [SW-1:0] tag_s [1:NW];

	genvar k;
	for (k = 0; k < NW; k++) begin : g_stage
		logic [DW-1:0] rem_c;
		logic [NW-1:0] nq_c;
		logic [DW-1:0] den_c;
		logic [SW-1:0] tag_c;
		logic [DW:0]   trial;
		logic [DW+1:0] diff;

		if (k == 0) begin : g_first
			assign rem_c = '0;
			assign nq_c = num;
			assign den_c = den;
			assign tag_c = tag_i;
		end else begin : g_next
			assign rem_c = rem_s[k];
			assign nq_c = nq_s[k];
			assign den_c = den_s[k];
			assign tag_c = tag_s[k];
		end

		assign trial = {rem_c, nq_c[NW-1]};
		assign diff = {1'b0, trial} - {2'b00, den_c};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k+1] <= '0;
			end else if (en) begin
				tag_s[k+1] <= tag_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[DW+1]) begin
					rem_s[k+1] <= diff[DW-1:0];
					nq_s[k+1] <= {nq_c[NW-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= trial[DW-1:0];
					nq_s[k+1] <= {nq_c[NW-2:0], 1'b0};
				end
				den_s[k+1] <= den_c;
			end
		end
	end

	assign quo = nq_s[NW];
	assign tag_o = tag_s[NW];

endmodule
`default_nettype wire

### rtl/mcls_lane.sv
// one candidate lane: scales both targets by a factor and checks them against the windows
`default_nettype none
module mcls_lane #(
	parameter int SCALE_FRAC_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            en,
	input  wire logic signed [SCALE_FRAC_BITS+16:0] fac,
	input  wire logic                            ok,
	input  wire logic signed [15:0]              tgt_l,
	input  wire logic signed [15:0]              tgt_r,
	input  wire logic signed [15:0]              lo_l,
	input  wire logic signed [15:0]              hi_l,
	input  wire logic signed [15:0]              lo_r,
	input  wire logic signed [15:0]              hi_r,
	output logic                                 fits,
	output logic signed [15:0]                   v_l,
	output logic signed [15:0]                   v_r,
	output logic        [SCALE_FRAC_BITS+15:0]   gap
);

	localparam int FB = SCALE_FRAC_BITS;
	localparam int QW = FB + 16;
	localparam int FW = QW + 1;
	localparam int PW = FW + 16;

	localparam logic signed [FW:0] ONE = {{(FW-FB){1'b0}}, 1'b1, {FB{1'b0}}};
	localparam logic signed [PW-1:0] RND = {{(PW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};

	logic signed [PW-1:0] prod_l_s1;
	logic signed [PW-1:0] prod_r_s1;
	logic        [QW-1:0] dist_s1;
	logic                 ok_s1;

	logic signed [FW:0]   fac_off;
	logic signed [FW:0]   fac_abs;
	logic signed [PW-1:0] sum_l;
	logic signed [PW-1:0] sum_r;
	logic signed [PW-1:0] sc_l;
	logic signed [PW-1:0] sc_r;
	logic                 in_l;
	logic                 in_r;

	logic                 fits_s2;
	logic signed [15:0]   v_l_s2;
	logic signed [15:0]   v_r_s2;
	logic        [QW-1:0] dist_s2;

	assign fac_off = (FW+1)'(fac) - ONE;
	assign fac_abs = fac_off[FW] ? -fac_off : fac_off;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_l_s1 <= PW'(tgt_l) * PW'(fac);
			prod_r_s1 <= PW'(tgt_r) * PW'(fac);
			dist_s1 <= fac_abs[QW-1:0];
			ok_s1 <= ok;
		end
	end

	// round to nearest, ties up
	assign sum_l = prod_l_s1 + RND;
	assign sum_r = prod_r_s1 + RND;
	assign sc_l = sum_l >>> FB;
	assign sc_r = sum_r >>> FB;
	assign in_l = (sc_l >= PW'(lo_l)) && (sc_l <= PW'(hi_l));
	assign in_r = (sc_r >= PW'(lo_r)) && (sc_r <= PW'(hi_r));

	always_ff @(posedge clk) begin
		if (en) begin
			fits_s2 <= ok_s1 && in_l && in_r;
			v_l_s2 <= sc_l[15:0];
			v_r_s2 <= sc_r[15:0];
			dist_s2 <= dist_s1;
		end
	end

	assign fits = fits_s2;
	assign v_l = v_l_s2;
	assign v_r = v_r_s2;
	assign gap = dist_s2;

endmodule
`default_nettype wire

### rtl/motor_current_limit_scaler.sv
// top level of the motor current limit scaler
// The block takes one request per clock while not stalled and returns one result per
// request, in order. A request passes the back-emf product register and the window register,
// the four pipelined scale-factor dividers, the five candidate lanes, the merge registers,
// the power multiply, the pipelined battery divider and the output register. The pipeline
// stalls only when the output register is full, not taken, and an item is waiting behind it;
// bubbles close up. Configuration writes are taken every cycle and should be made while the
// block is idle.
`default_nettype none
module motor_current_limit_scaler import mcls_pkg::*; #(
	parameter int SCALE_FRAC_BITS = SCALE_FRAC_BITS_DEF
) (
	input wire logic     clk,
	input wire logic     arst_n,
	mcls_sample_if.sink  sample,
	mcls_result_if.source result,
	mcls_cfg_if.sink     cfg
);

	localparam int FB = SCALE_FRAC_BITS;
	localparam int QW = FB + 16;
	localparam int FW = QW + 1;

	localparam logic signed [FW-1:0] ONE = {{(FW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};

	typedef struct packed {
		logic signed [15:0] lo_l;
		logic signed [15:0] hi_l;
		logic signed [15:0] lo_r;
		logic signed [15:0] hi_r;
		logic signed [15:0] tgt_l;
		logic signed [15:0] tgt_r;
		logic        [15:0] bat;
		logic               vld;
	} sb_t;

	typedef struct packed {
		logic    vld;
		logic    fault;
		kind_t   kind;
		logic    neg;
	} ptag_t;

	typedef struct packed {
		logic               fits;
		logic signed [15:0] v_l;
		logic signed [15:0] v_r;
		logic [QW-1:0]      gap;
	} cand_t;

	function automatic cand_t pick(input cand_t a, input cand_t b);
		if (b.fits && (!a.fits || (b.gap < a.gap))) begin
			return b;
		end
		return a;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [33:0] x);
		if (x < -34'sd32768) begin
			return -16'sd32768;
		end else if (x > 34'sd32767) begin
			return 16'sd32767;
		end
		return x[15:0];
	endfunction

	function automatic logic [15:0] abs16(input logic signed [15:0] x);
		logic signed [15:0] n;
		n = -x;
		return x[15] ? n : x;
	endfunction

	function automatic logic signed [15:0] clamp(input logic signed [15:0] x,
		input logic signed [15:0] lo, input logic signed [15:0] hi);
		if (x < lo) begin
			return lo;
		end else if (x > hi) begin
			return hi;
		end
		return x;
	endfunction

	// configuration
	logic [15:0] gain_q;
	logic [14:0] drop_q;
	logic [15:0] maxp_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RST;
			drop_q <= DROP_RST;
			maxp_q <= MAXP_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BACK_EMF_GAIN: gain_q <= cfg.data;
				REG_CURRENT_DROP:  drop_q <= cfg.data[14:0];
				REG_MAX_POWER:     maxp_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// flow control
	logic  out_vld_q;
	logic  out_load;
	logic  adv;
	ptag_t ptag_l;

	assign out_load = !out_vld_q || result.ready;
	assign adv = out_load || !ptag_l.vld;
	assign sample.ready = adv;

	// back-emf products
	logic               vld_s1;
	logic signed [32:0] emf_l_s1;
	logic signed [32:0] emf_r_s1;
	logic signed [15:0] tgt_l_s1;
	logic signed [15:0] tgt_r_s1;
	logic        [15:0] bat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			emf_l_s1 <= 33'(sample.speed_left) * 33'($signed({1'b0, gain_q}));
			emf_r_s1 <= 33'(sample.speed_right) * 33'($signed({1'b0, gain_q}));
			tgt_l_s1 <= sample.target_left;
			tgt_r_s1 <= sample.target_right;
			bat_s1 <= sample.battery_mv;
		end
	end

	// voltage windows
	logic signed [32:0] emf_l;
	logic signed [32:0] emf_r;
	logic signed [33:0] drop_x;
	sb_t                sb_c2;
	sb_t                sb_s2;

	assign emf_l = (emf_l_s1 + 33'sd128) >>> 8;
	assign emf_r = (emf_r_s1 + 33'sd128) >>> 8;
	assign drop_x = $signed({19'b0, drop_q});

	always_comb begin
		sb_c2.lo_l = sat16(34'(emf_l) - drop_x);
		sb_c2.hi_l = sat16(34'(emf_l) + drop_x);
		sb_c2.lo_r = sat16(34'(emf_r) - drop_x);
		sb_c2.hi_r = sat16(34'(emf_r) + drop_x);
		sb_c2.tgt_l = tgt_l_s1;
		sb_c2.tgt_r = tgt_r_s1;
		sb_c2.bat = bat_s1;
		sb_c2.vld = vld_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_s2 <= '0;
		end else if (adv) begin
			sb_s2 <= sb_c2;
		end
	end

	// scale factor dividers: hi_l, hi_r, lo_l, lo_r over their targets
	logic signed [15:0] bnd [CAND_N-1];
	logic signed [15:0] dtg [CAND_N-1];
	logic [QW-1:0]      quo [CAND_N-1];
	logic               neg [CAND_N-1];
	logic               okd [CAND_N-1];
	logic signed [FW-1:0] fac [CAND_N];
	logic               ok  [CAND_N];
	sb_t                sb_s3;

	assign bnd[0] = sb_s2.hi_l;
	assign bnd[1] = sb_s2.hi_r;
	assign bnd[2] = sb_s2.lo_l;
	assign bnd[3] = sb_s2.lo_r;
	assign dtg[0] = sb_s2.tgt_l;
	assign dtg[1] = sb_s2.tgt_r;
	assign dtg[2] = sb_s2.tgt_l;
	assign dtg[3] = sb_s2.tgt_r;

	genvar i;
	for (i = 0; i < CAND_N - 1; i++) begin : g_div
		logic [QW-1:0] num;
		logic          neg_i;
		logic          ok_i;

		assign num = {abs16(bnd[i]), {FB{1'b0}}};
		assign neg_i = bnd[i][15] ^ dtg[i][15];
		assign ok_i = dtg[i] != 16'sd0;

		if (i == 0) begin : g_main
			logic [$bits(sb_t)+1:0] tag_o;
			mcls_div #(.NW(QW), .DW(16), .SW($bits(sb_t) + 2)) u_div (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (adv),
				.num    (num),
				.den    (abs16(dtg[i])),
				.tag_i  ({sb_s2, neg_i, ok_i}),
				.quo    (quo[i]),
				.tag_o  (tag_o)
			);
			assign sb_s3 = tag_o[$bits(sb_t)+1:2];
			assign neg[i] = tag_o[1];
			assign okd[i] = tag_o[0];
		end else begin : g_side
			logic [1:0] tag_o;
			mcls_div #(.NW(QW), .DW(16), .SW(2)) u_div (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (adv),
				.num    (num),
				.den    (abs16(dtg[i])),
				.tag_i  ({neg_i, ok_i}),
				.quo    (quo[i]),
				.tag_o  (tag_o)
			);
			assign neg[i] = tag_o[1];
			assign okd[i] = tag_o[0];
		end

		assign fac[i] = neg[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
		assign ok[i] = okd[i];
	end

	assign fac[CAND_N-1] = ONE;
	assign ok[CAND_N-1] = 1'b1;

	// candidate lanes
	sb_t   sb_s4;
	sb_t   sb_s5;
	cand_t cand [CAND_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_s4 <= '0;
			sb_s5 <= '0;
		end else if (adv) begin
			sb_s4 <= sb_s3;
			sb_s5 <= sb_s4;
		end
	end

	for (i = 0; i < CAND_N; i++) begin : g_lane
		mcls_lane #(.SCALE_FRAC_BITS(FB)) u_lane (
			.clk   (clk),
			.en    (adv),
			.fac   (fac[i]),
			.ok    (ok[i]),
			.tgt_l (sb_s3.tgt_l),
			.tgt_r (sb_s3.tgt_r),
			.lo_l  (sb_s4.lo_l),
			.hi_l  (sb_s4.hi_l),
			.lo_r  (sb_s4.lo_r),
			.hi_r  (sb_s4.hi_r),
			.fits  (cand[i].fits),
			.v_l   (cand[i].v_l),
			.v_r   (cand[i].v_r),
			.gap   (cand[i].gap)
		);
	end

	// merge: nearest to one, earliest wins ties
	cand_t p01_s6;
	cand_t p23_s6;
	cand_t c4_s6;
	sb_t   sb_s6;
	cand_t p03_s7;
	cand_t c4_s7;
	sb_t   sb_s7;
	cand_t best;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_s6 <= '0;
			sb_s7 <= '0;
		end else if (adv) begin
			sb_s6 <= sb_s5;
			sb_s7 <= sb_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p01_s6 <= pick(cand[0], cand[1]);
			p23_s6 <= pick(cand[2], cand[3]);
			c4_s6 <= cand[CAND_N-1];
			p03_s7 <= pick(p01_s6, p23_s6);
			c4_s7 <= c4_s6;
		end
	end

	assign best = pick(p03_s7, c4_s7);

	logic signed [15:0] res_l_s8;
	logic signed [15:0] res_r_s8;
	kind_t              kind_s8;
	logic               fault_s8;
	logic        [15:0] bat_s8;
	logic               vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s8 <= sb_s7.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (best.fits) begin
				res_l_s8 <= best.v_l;
				res_r_s8 <= best.v_r;
				kind_s8 <= (best.gap == '0) ? KIND_UNSCALED : KIND_SCALED;
			end else begin
				res_l_s8 <= clamp(sb_s7.tgt_l, sb_s7.lo_l, sb_s7.hi_l);
				res_r_s8 <= clamp(sb_s7.tgt_r, sb_s7.lo_r, sb_s7.hi_r);
				kind_s8 <= KIND_CLAMPED;
			end
			fault_s8 <= sb_s7.bat == 16'd0;
			bat_s8 <= sb_s7.bat;
		end
	end

	// power scaling
	logic signed [32:0] pw_l_s9;
	logic signed [32:0] pw_r_s9;
	logic        [15:0] bat_s9;
	ptag_t              ptag_s9;
	logic signed [32:0] pw_l_n;
	logic signed [32:0] pw_r_n;
	logic [PWR_NW-1:0]  q_l;
	logic [PWR_NW-1:0]  q_r;
	logic               neg_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptag_s9 <= '0;
		end else if (adv) begin
			ptag_s9.vld <= vld_s8;
			ptag_s9.fault <= fault_s8;
			ptag_s9.kind <= kind_s8;
			ptag_s9.neg <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pw_l_s9 <= 33'(res_l_s8) * 33'($signed({1'b0, maxp_q}));
			pw_r_s9 <= 33'(res_r_s8) * 33'($signed({1'b0, maxp_q}));
			bat_s9 <= bat_s8;
		end
	end

	assign pw_l_n = -pw_l_s9;
	assign pw_r_n = -pw_r_s9;

	mcls_div #(.NW(PWR_NW), .DW(16), .SW($bits(ptag_t))) u_pdiv_l (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.num    (pw_l_s9[32] ? pw_l_n[PWR_NW-1:0] : pw_l_s9[PWR_NW-1:0]),
		.den    (bat_s9),
		.tag_i  ({ptag_s9.vld, ptag_s9.fault, ptag_s9.kind, pw_l_s9[32]}),
		.quo    (q_l),
		.tag_o  (ptag_l)
	);

	mcls_div #(.NW(PWR_NW), .DW(16), .SW(1)) u_pdiv_r (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.num    (pw_r_s9[32] ? pw_r_n[PWR_NW-1:0] : pw_r_s9[PWR_NW-1:0]),
		.den    (bat_s9),
		.tag_i  (pw_r_s9[32]),
		.quo    (q_r),
		.tag_o  (neg_r)
	);

	// saturation and output register
	logic        [16:0] mag_l;
	logic        [16:0] mag_r;
	logic signed [16:0] pl_q;
	logic signed [16:0] pr_q;
	kind_t              kind_q;
	logic               fault_q;

	assign mag_l = (q_l > PWR_NW'(PWR_SAT)) ? PWR_SAT : q_l[16:0];
	assign mag_r = (q_r > PWR_NW'(PWR_SAT)) ? PWR_SAT : q_r[16:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= ptag_l.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (ptag_l.fault) begin
				pl_q <= '0;
				pr_q <= '0;
				kind_q <= KIND_UNSCALED;
			end else begin
				pl_q <= ptag_l.neg ? -$signed(mag_l) : $signed(mag_l);
				pr_q <= neg_r ? -$signed(mag_r) : $signed(mag_r);
				kind_q <= ptag_l.kind;
			end
			fault_q <= ptag_l.fault;
		end
	end

	assign result.valid = out_vld_q;
	assign result.power_left = pl_q;
	assign result.power_right = pr_q;
	assign result.limit_kind = kind_q;
	assign result.battery_fault = fault_q;

endmodule
`default_nettype wire

### rtl/mcls_checker.sv
// port-level checks for the motor current limit scaler and their bind
`default_nettype none
module mcls_checker import mcls_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic signed [16:0] power_left,
	input wire logic signed [16:0] power_right,
	input wire logic [1:0]        limit_kind,
	input wire logic              battery_fault,
	input wire logic              cfg_ready
);

	// a result waiting to be taken stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// fault gives zero commands and no limit kind
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && battery_fault |-> power_left == 17'sd0 && power_right == 17'sd0
			&& limit_kind == KIND_UNSCALED)
		else $error("battery fault with nonzero outputs");

	// saturation keeps both commands within plus or minus full scale
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> power_left != -17'sd65536 && power_right != -17'sd65536)
		else $error("power command out of range");

	// empty output means requests are taken
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request stalled with empty output");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration write refused");

endmodule

bind motor_current_limit_scaler mcls_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (sample.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.power_left    (result.power_left),
	.power_right   (result.power_right),
	.limit_kind    (result.limit_kind),
	.battery_fault (result.battery_fault),
	.cfg_ready     (cfg.ready)
);
`default_nettype wire
